>>> rtl/core/stl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_pkg
// Result record, lexer mode codes, token kinds and keyword lookup for the
// script token lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

   typedef struct packed {
      logic [1:0]  kind;
      logic [5:0]  token_kind;
      logic [15:0] line;
      logic [15:0] column;
      logic [23:0] text_offset;
      logic [15:0] lexeme_length;
      logic        is_final;
   } result_type;

   typedef struct packed {
      logic [1:0] push_count;
   } fifo_ctl_type;

   localparam logic [1:0] KIND_TOKEN   = 2'd0;
   localparam logic [1:0] KIND_UNKNOWN = 2'd1;
   localparam logic [1:0] KIND_UNENDED = 2'd2;

   localparam logic [2:0] M_IDLE    = 3'd0;
   localparam logic [2:0] M_OP      = 3'd1;
   localparam logic [2:0] M_SLASH   = 3'd2;
   localparam logic [2:0] M_COMMENT = 3'd3;
   localparam logic [2:0] M_STRING  = 3'd4;
   localparam logic [2:0] M_INT     = 3'd5;
   localparam logic [2:0] M_FRAC    = 3'd6;
   localparam logic [2:0] M_IDENT   = 3'd7;

   localparam logic [5:0] TK_EQUALS       = 6'd0;
   localparam logic [5:0] TK_LESS         = 6'd2;
   localparam logic [5:0] TK_MORE         = 6'd4;
   localparam logic [5:0] TK_BANG_EQUAL   = 6'd6;
   localparam logic [5:0] TK_PLUS         = 6'd7;
   localparam logic [5:0] TK_MINUS        = 6'd8;
   localparam logic [5:0] TK_STAR         = 6'd9;
   localparam logic [5:0] TK_SLASH        = 6'd10;
   localparam logic [5:0] TK_LEFT_SQUARE  = 6'd11;
   localparam logic [5:0] TK_RIGHT_SQUARE = 6'd12;
   localparam logic [5:0] TK_LEFT_BRACE   = 6'd13;
   localparam logic [5:0] TK_RIGHT_BRACE  = 6'd14;
   localparam logic [5:0] TK_LEFT_PAREN   = 6'd15;
   localparam logic [5:0] TK_RIGHT_PAREN  = 6'd16;
   localparam logic [5:0] TK_COMMA        = 6'd17;
   localparam logic [5:0] TK_SEMICOLON    = 6'd18;
   localparam logic [5:0] TK_COLON        = 6'd19;
   localparam logic [5:0] TK_STRING       = 6'd20;
   localparam logic [5:0] TK_NUMBER       = 6'd21;
   localparam logic [5:0] TK_IDENT        = 6'd22;
   localparam logic [5:0] TK_END          = 6'd35;

   localparam int KW_COUNT = 12;

   localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
      64'("var"), 64'("if"), 64'("while"), 64'("do"), 64'("break"), 64'("for"),
      64'("foreach"), 64'("true"), 64'("false"), 64'("in"), 64'("function"),
      64'("return")
   };
   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd3, 4'd2, 4'd5, 4'd2, 4'd5, 4'd3, 4'd7, 4'd4, 4'd5, 4'd2, 4'd8, 4'd6
   };
   localparam logic [5:0] KW_KIND [KW_COUNT] = '{
      6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32,
      6'd33, 6'd34
   };

   // buf holds byte i at [8*i+:8]; len is at most 8 here
   function automatic logic [5:0] kw_lookup(input logic [63:0] buf_bytes,
                                            input logic [15:0] len);
      logic [63:0] packed_text;
      logic [5:0]  kind;
      packed_text = '0;
      kind        = TK_IDENT;
      for (int i = 0; i < 8; i++) begin
         if (16'(i) < len) begin
            packed_text = {packed_text[55:0], buf_bytes[8*i +: 8]};
         end
      end
      for (int k = 0; k < KW_COUNT; k++) begin
         if (len == 16'(KW_LEN[k]) && packed_text == KW_TEXT[k]) begin
            kind = KW_KIND[k];
         end
      end
      return kind;
   endfunction

endpackage

>>> rtl/core/stl_result_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_result_fifo
// Four-entry result queue; takes up to two results per cycle, gives one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module stl_result_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  stl_pkg::fifo_ctl_type ctl,
   input  stl_pkg::result_type  push0,
   input  stl_pkg::result_type  push1,
   output logic                 room,
   output logic                 out_valid,
   input  logic                 out_ready,
   output stl_pkg::result_type  out_data
);
   import stl_pkg::*;

   result_type  mem_ff [4];
   logic [1:0]  rd_ff, rd_in;
   logic [1:0]  wr_ff, wr_in;
   logic [2:0]  count_ff, count_in;
   logic        pop;

   assign out_valid = (count_ff != 3'd0);
   assign out_data  = mem_ff[rd_ff];
   assign pop       = out_valid && out_ready;
   assign room      = (count_ff <= 3'd2);

   always_comb begin
      rd_in    = pop ? rd_ff + 2'd1 : rd_ff;
      wr_in    = wr_ff + ctl.push_count;
      count_in = count_ff + 3'(ctl.push_count) - (pop ? 3'd1 : 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff    <= '0;
         wr_ff    <= '0;
         count_ff <= '0;
      end else begin
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push_count != 2'd0) begin
         mem_ff[wr_ff] <= push0;
      end
      if (ctl.push_count == 2'd2) begin
         mem_ff[wr_ff + 2'd1] <= push1;
      end
   end

endmodule

>>> rtl/core/script_token_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// script_token_lexer
// Streaming tokenizer: one source byte or end marker per item in, tokens out.
// ----------------------------------------------------------------------------
// One item is taken per cycle. A byte is registered, then decoded combinationally
// against the lexer state, giving zero, one or two results into a four-entry
// result queue; input stalls only while that queue holds three or more results.
// A result goes from the input register through the result queue to the output.
module script_token_lexer #(
   parameter int KEYWORD_MAX_LEN = 8,
   parameter int POSITION_BITS   = 24,
   parameter int LINE_BITS       = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_ch,
   input  logic        req_end_of_source,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [5:0]  rsp_token_kind,
   output logic [15:0] rsp_line,
   output logic [15:0] rsp_column,
   output logic [23:0] rsp_text_offset,
   output logic [15:0] rsp_lexeme_length,
   output logic        rsp_is_final
);
   import stl_pkg::*;

   localparam int LW = (LINE_BITS > 16) ? LINE_BITS : 16;
   localparam int PW = (POSITION_BITS > 24) ? POSITION_BITS : 24;
   localparam int KW = KEYWORD_MAX_LEN * 8;

   logic                     in_valid_ff;
   logic [7:0]               ch_ff;
   logic                     eos_ff;
   logic [2:0]               mode_ff, mode_in;
   logic [7:0]               pend_op_ff, pend_op_in;
   logic [LINE_BITS-1:0]     line_ff, line_in;
   logic [15:0]              col_ff, col_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [LINE_BITS-1:0]     ts_line_ff, ts_line_in;
   logic [15:0]              ts_col_ff, ts_col_in;
   logic [POSITION_BITS-1:0] ts_pos_ff, ts_pos_in;
   logic [15:0]              tok_len_ff, tok_len_in;
   logic [KW-1:0]            kwbuf_ff, kwbuf_in;

   logic                     fire, room;
   fifo_ctl_type             fctl;
   result_type               r0, r1, pend_res, idle_res, end_res, fifo_out;
   logic [1:0]               n_res;

   logic                     id_begin, id_emit;
   logic [2:0]               id_mode;
   logic [POSITION_BITS-1:0] id_pos;
   logic [15:0]              id_len;
   logic                     do_idle, emit_pend;
   logic [5:0]               ident_tk;
   logic [POSITION_BITS-1:0] pos_inc;
   logic [LINE_BITS-1:0]     line_inc;
   logic                     is_digit, is_alpha;

   function automatic logic [15:0] line16(input logic [LINE_BITS-1:0] v);
      logic [LW-1:0] e;
      e = LW'(v);
      return (e > LW'(17'h0FFFF)) ? 16'hFFFF : e[15:0];
   endfunction

   function automatic logic [23:0] pos24(input logic [POSITION_BITS-1:0] v);
      logic [PW-1:0] e;
      e = PW'(v);
      return (e > PW'(25'h0FFFFFF)) ? 24'hFFFFFF : e[23:0];
   endfunction

   assign fire      = in_valid_ff && room;
   assign req_ready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         ch_ff  <= req_ch;
         eos_ff <= req_end_of_source;
      end
   end

   assign pos_inc  = (pos_ff == '1) ? pos_ff : pos_ff + POSITION_BITS'(1);
   assign line_inc = (line_ff == '1) ? line_ff : line_ff + LINE_BITS'(1);
   assign is_digit = (ch_ff >= "0") && (ch_ff <= "9");
   assign is_alpha = ((ch_ff >= "a") && (ch_ff <= "z")) ||
                     ((ch_ff >= "A") && (ch_ff <= "Z"));
   assign ident_tk = (tok_len_ff > 16'(KEYWORD_MAX_LEN)) ? TK_IDENT :
                     kw_lookup(kwbuf_ff[63:0], tok_len_ff);

   // byte handled as the first byte of a token
   always_comb begin
      id_begin = 1'b0;
      id_emit  = 1'b0;
      id_mode  = M_IDLE;
      id_pos   = pos_ff;
      id_len   = 16'd1;
      idle_res = '{kind: KIND_TOKEN, token_kind: TK_EQUALS, line: line16(line_ff),
                   column: col_ff, text_offset: pos24(pos_ff),
                   lexeme_length: 16'd1, is_final: 1'b0};
      case (ch_ff) inside
         8'h0A, 8'h20, 8'h09, 8'h0D: ;
         "=", "<", ">", "!": begin
            id_begin = 1'b1;
            id_mode  = M_OP;
         end
         "/": begin
            id_begin = 1'b1;
            id_mode  = M_SLASH;
         end
         8'h27: begin
            id_begin = 1'b1;
            id_mode  = M_STRING;
            id_pos   = pos_inc;
            id_len   = 16'd0;
         end
         ["0":"9"]: begin
            id_begin = 1'b1;
            id_mode  = M_INT;
         end
         ["a":"z"], ["A":"Z"], "_": begin
            id_begin = 1'b1;
            id_mode  = M_IDENT;
         end
         "+": begin id_emit = 1'b1; idle_res.token_kind = TK_PLUS; end
         "-": begin id_emit = 1'b1; idle_res.token_kind = TK_MINUS; end
         "*": begin id_emit = 1'b1; idle_res.token_kind = TK_STAR; end
         "[": begin id_emit = 1'b1; idle_res.token_kind = TK_LEFT_SQUARE; end
         "]": begin id_emit = 1'b1; idle_res.token_kind = TK_RIGHT_SQUARE; end
         "{": begin id_emit = 1'b1; idle_res.token_kind = TK_LEFT_BRACE; end
         "}": begin id_emit = 1'b1; idle_res.token_kind = TK_RIGHT_BRACE; end
         "(": begin id_emit = 1'b1; idle_res.token_kind = TK_LEFT_PAREN; end
         ")": begin id_emit = 1'b1; idle_res.token_kind = TK_RIGHT_PAREN; end
         ",": begin id_emit = 1'b1; idle_res.token_kind = TK_COMMA; end
         ";": begin id_emit = 1'b1; idle_res.token_kind = TK_SEMICOLON; end
         ":": begin id_emit = 1'b1; idle_res.token_kind = TK_COLON; end
         default: begin
            id_emit       = 1'b1;
            idle_res.kind = KIND_UNKNOWN;
         end
      endcase
   end

   always_comb begin
      mode_in    = mode_ff;
      pend_op_in = pend_op_ff;
      line_in    = line_ff;
      col_in     = col_ff;
      pos_in     = pos_ff;
      ts_line_in = ts_line_ff;
      ts_col_in  = ts_col_ff;
      ts_pos_in  = ts_pos_ff;
      tok_len_in = tok_len_ff;
      kwbuf_in   = kwbuf_ff;
      do_idle    = 1'b0;
      emit_pend  = 1'b0;
      pend_res   = '{kind: KIND_TOKEN, token_kind: TK_EQUALS, line: line16(ts_line_ff),
                     column: ts_col_ff, text_offset: pos24(ts_pos_ff),
                     lexeme_length: tok_len_ff, is_final: 1'b0};
      end_res    = '{kind: KIND_TOKEN, token_kind: TK_END, line: line16(line_inc),
                     column: 16'd0, text_offset: pos24(pos_ff),
                     lexeme_length: 16'd0, is_final: 1'b1};
      r0    = pend_res;
      r1    = pend_res;
      n_res = 2'd0;

      if (eos_ff) begin
         emit_pend = 1'b1;
         unique case (mode_ff)
            M_OP:     pend_res.token_kind = (pend_op_ff == "=") ? TK_EQUALS :
                                            (pend_op_ff == "<") ? TK_LESS :
                                            (pend_op_ff == ">") ? TK_MORE : TK_BANG_EQUAL;
            M_SLASH:  pend_res.token_kind = TK_SLASH;
            M_INT, M_FRAC: pend_res.token_kind = TK_NUMBER;
            M_IDENT:  pend_res.token_kind = ident_tk;
            M_STRING: begin
               pend_res.kind       = KIND_UNENDED;
               pend_res.token_kind = TK_STRING;
            end
            default:  emit_pend = 1'b0;
         endcase
         if (emit_pend) begin
            r0    = pend_res;
            r1    = end_res;
            n_res = 2'd2;
         end else begin
            r0    = end_res;
            n_res = 2'd1;
         end
         mode_in    = M_IDLE;
         pend_op_in = '0;
         line_in    = LINE_BITS'(1);
         col_in     = '0;
         pos_in     = '0;
         ts_line_in = '0;
         ts_col_in  = '0;
         ts_pos_in  = '0;
         tok_len_in = '0;
         kwbuf_in   = '0;
      end else begin
         pend_res.token_kind = (pend_op_ff == "=") ? TK_EQUALS :
                               (pend_op_ff == "<") ? TK_LESS :
                               (pend_op_ff == ">") ? TK_MORE : TK_BANG_EQUAL;
         unique case (mode_ff)
            M_OP: begin
               emit_pend = 1'b1;
               if (ch_ff == "=") begin
                  tok_len_in              = 16'd2;
                  pend_res.lexeme_length  = 16'd2;
                  if (pend_op_ff != "!") begin
                     pend_res.token_kind = pend_res.token_kind + 6'd1;
                  end
                  mode_in = M_IDLE;
               end else begin
                  do_idle = 1'b1;
               end
            end
            M_SLASH: begin
               if (ch_ff == "/") begin
                  mode_in = M_COMMENT;
               end else begin
                  emit_pend           = 1'b1;
                  pend_res.token_kind = TK_SLASH;
                  do_idle             = 1'b1;
               end
            end
            M_COMMENT: begin
               if (ch_ff == 8'h0A) begin
                  mode_in = M_IDLE;
               end
            end
            M_STRING: begin
               if (ch_ff == 8'h27) begin
                  emit_pend           = 1'b1;
                  pend_res.token_kind = TK_STRING;
                  mode_in             = M_IDLE;
               end else if (tok_len_ff != 16'hFFFF) begin
                  tok_len_in = tok_len_ff + 16'd1;
               end
            end
            M_INT, M_FRAC: begin
               if (is_digit || (ch_ff == "." && mode_ff == M_INT)) begin
                  if (tok_len_ff != 16'hFFFF) begin
                     tok_len_in = tok_len_ff + 16'd1;
                  end
                  if (!is_digit) begin
                     mode_in = M_FRAC;
                  end
               end else begin
                  emit_pend           = 1'b1;
                  pend_res.token_kind = TK_NUMBER;
                  do_idle             = 1'b1;
               end
            end
            M_IDENT: begin
               if (is_alpha || is_digit || ch_ff == "_") begin
                  for (int j = 0; j < KEYWORD_MAX_LEN; j++) begin
                     if (tok_len_ff == 16'(j)) begin
                        kwbuf_in[8*j +: 8] = ch_ff;
                     end
                  end
                  if (tok_len_ff != 16'hFFFF) begin
                     tok_len_in = tok_len_ff + 16'd1;
                  end
               end else begin
                  emit_pend           = 1'b1;
                  pend_res.token_kind = ident_tk;
                  do_idle             = 1'b1;
               end
            end
            default: do_idle = 1'b1;
         endcase

         if (do_idle) begin
            mode_in = id_mode;
            if (id_begin) begin
               ts_line_in = line_ff;
               ts_col_in  = col_ff;
               ts_pos_in  = id_pos;
               tok_len_in = id_len;
               if (id_mode == M_OP) begin
                  pend_op_in = ch_ff;
               end
               if (id_mode == M_IDENT) begin
                  kwbuf_in[7:0] = ch_ff;
               end
            end
         end

         if (emit_pend) begin
            r0 = pend_res;
            r1 = idle_res;
            n_res = (do_idle && id_emit) ? 2'd2 : 2'd1;
         end else if (do_idle && id_emit) begin
            r0    = idle_res;
            n_res = 2'd1;
         end

         pos_in = pos_inc;
         if (ch_ff == 8'h0A) begin
            line_in = line_inc;
            col_in  = '0;
         end else if (col_ff != 16'hFFFF) begin
            col_in = col_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= M_IDLE;
         pend_op_ff <= '0;
         line_ff    <= LINE_BITS'(1);
         col_ff     <= '0;
         pos_ff     <= '0;
         ts_line_ff <= '0;
         ts_col_ff  <= '0;
         ts_pos_ff  <= '0;
         tok_len_ff <= '0;
         kwbuf_ff   <= '0;
      end else if (fire) begin
         mode_ff    <= mode_in;
         pend_op_ff <= pend_op_in;
         line_ff    <= line_in;
         col_ff     <= col_in;
         pos_ff     <= pos_in;
         ts_line_ff <= ts_line_in;
         ts_col_ff  <= ts_col_in;
         ts_pos_ff  <= ts_pos_in;
         tok_len_ff <= tok_len_in;
         kwbuf_ff   <= kwbuf_in;
      end
   end

   assign fctl.push_count = fire ? n_res : 2'd0;

   stl_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .ctl       (fctl),
      .push0     (r0),
      .push1     (r1),
      .room      (room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (fifo_out)
   );

   assign rsp_kind          = fifo_out.kind;
   assign rsp_token_kind    = fifo_out.token_kind;
   assign rsp_line          = fifo_out.line;
   assign rsp_column        = fifo_out.column;
   assign rsp_text_offset   = fifo_out.text_offset;
   assign rsp_lexeme_length = fifo_out.lexeme_length;
   assign rsp_is_final      = fifo_out.is_final;

endmodule
